>>> hw/rtl/swpa_pkg.sv
package swpa_pkg;

    // Width of one assembled event as held in the history.
    localparam int EVENT_W = 48;

    // Width of the stored first half: ms[9:0], sec[15:10], min[21:16].
    localparam int FIRST_W = 22;

    // Default number of history entries.
    localparam int HISTORY_DEPTH_DEF = 16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FIRST = 2'd0,
        ST_EMIT  = 2'd1,
        ST_SEQ   = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Control from the sequencer to the history chain.
    typedef struct packed {
        logic shift;
        logic insert;
    } t_chain_ctl;

endpackage

>>> hw/rtl/swpa_cell.sv
// One entry of the event history. It loads its neighbor's entry on a shift.
module swpa_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [swpa_pkg::EVENT_W-1:0]   i_data,
    output logic [swpa_pkg::EVENT_W-1:0]   o_data
);

    logic [swpa_pkg::EVENT_W-1:0] r_entry;

    // The history is defined as all zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_data;
        end
    end

    assign o_data = r_entry;

endmodule

>>> hw/rtl/swpa_history_chain.sv
// Row of history cells. The chain either rotates (the head entry wraps to the
// tail) or takes a new event at the tail and drops the oldest at the head.
module swpa_history_chain #(
    parameter int HISTORY_DEPTH = swpa_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swpa_pkg::t_chain_ctl           i_ctl,
    input  logic [swpa_pkg::EVENT_W-1:0]   i_event,
    output logic [swpa_pkg::EVENT_W-1:0]   o_head
);

    logic [swpa_pkg::EVENT_W-1:0] w_cell [HISTORY_DEPTH];
    logic [swpa_pkg::EVENT_W-1:0] w_tail_in;

    // New event enters on insert; otherwise the oldest entry wraps around.
    assign w_tail_in = i_ctl.insert ? i_event : w_cell[HISTORY_DEPTH-1];

    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            swpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_data  (w_tail_in),
                .o_data  (w_cell[k])
            );
        end else begin : g_next
            swpa_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_data  (w_cell[k-1]),
                .o_data  (w_cell[k])
            );
        end
    end

    assign o_head = w_cell[HISTORY_DEPTH-1];

endmodule

>>> hw/rtl/soe_word_pair_assembler_dedup_unit.sv
// A first half or a rejected word gives its item in the cycle after acceptance; a valid
// second half gives its item after the S_SCAN state, in which the history chain makes one
// full rotation past the compare at its head, and then the S_DONE state. First halves and
// rejected words go at one item per cycle while the output is not stalled; a valid second
// half holds off new words until its item is loaded. Reset (synchronous, active low) clears
// the flag, the pending half and every history entry at once; no clearing pass is needed.
module soe_word_pair_assembler_dedup_unit #(
    parameter int HISTORY_DEPTH = swpa_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // function_code[7:0], info_byte_one[15:8], info_byte_two[23:16],
    // info_byte_three[31:24], info_byte_four[39:32], previous_function_code[47:40]
    input  logic [47:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // point_number[11:0], point_state[12], milliseconds[22:13], seconds[28:23],
    // minutes[34:29], hours[39:35], day_of_month[44:40], zero fill[47:45]
    output logic [47:0] o_m_tdata,
    // status[1:0]
    output logic [1:0]  o_m_tuser
);

    localparam int CNT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // Input fields.
    logic [7:0] w_code, w_b1, w_b2, w_b3, w_b4, w_prev;
    assign w_code = i_s_tdata[7:0];
    assign w_b1   = i_s_tdata[15:8];
    assign w_b2   = i_s_tdata[23:16];
    assign w_b3   = i_s_tdata[31:24];
    assign w_b4   = i_s_tdata[39:32];
    assign w_prev = i_s_tdata[47:40];

    swpa_pkg::t_state r_state, n_state;
    logic                                r_waiting;
    logic [swpa_pkg::FIRST_W-1:0]        r_pending;
    logic [swpa_pkg::EVENT_W-1:0]        r_event;
    logic [CNT_W-1:0]                    r_cnt;
    logic                                r_dup;
    logic                                r_out_valid;
    swpa_pkg::t_status                   r_out_status;
    logic [47:0]                         r_out_data;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_in_seq;
    logic                                w_scan_last;
    logic                                w_load_done;
    logic [swpa_pkg::EVENT_W-1:0]        w_head;
    logic [47:0]                         w_emit_data;
    swpa_pkg::t_chain_ctl                w_ctl;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == swpa_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_seq    = ({1'b0, w_code} == ({1'b0, w_prev} + 9'd1)) && r_waiting;
    assign w_scan_last = (r_cnt == CNT_W'(HISTORY_DEPTH - 1));

    // Result fields unpacked from the assembled event.
    assign w_emit_data = {3'b000,
                          r_event[31:27],      // day
                          r_event[26:22],      // hour
                          r_event[21:16],      // minute
                          r_event[15:10],      // second
                          r_event[9:0],        // milliseconds
                          r_event[47],         // state
                          r_event[43:32]};     // point number

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swpa_pkg::S_IDLE: begin
                if (w_accept && w_code[0] && w_in_seq) begin
                    n_state = swpa_pkg::S_SCAN;
                end
            end
            swpa_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = swpa_pkg::S_DONE;
                end
            end
            swpa_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = swpa_pkg::S_IDLE;
                end
            end
            default: n_state = swpa_pkg::S_IDLE;
        endcase
    end

    // Chain control and result loading per state.
    always_comb begin
        w_ctl       = '0;
        w_load_done = 1'b0;
        unique case (r_state)
            swpa_pkg::S_IDLE: begin
                w_ctl = '0;
            end
            swpa_pkg::S_SCAN: begin
                w_ctl.shift = 1'b1;
            end
            swpa_pkg::S_DONE: begin
                w_load_done  = w_out_free;
                w_ctl.shift  = w_out_free && !r_dup;
                w_ctl.insert = w_out_free && !r_dup;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    swpa_history_chain #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_event (r_event),
        .o_head  (w_head)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swpa_pkg::S_IDLE;
            r_waiting   <= 1'b0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_dup       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_out_valid <= !(w_code[0] && w_in_seq);
                if (!w_code[0]) begin
                    r_pending <= {w_b4[5:0], w_b3[5:0], w_b2[1:0], w_b1};
                    r_waiting <= 1'b1;
                end else if (w_in_seq) begin
                    r_waiting <= 1'b0;
                    r_cnt     <= '0;
                    r_dup     <= 1'b0;
                end
            end else if (w_load_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // Compare each entry as it passes the head of the chain.
            if (r_state == swpa_pkg::S_SCAN) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_head == r_event) begin
                    r_dup <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= '0;
            if (!w_code[0]) begin
                r_out_status <= swpa_pkg::ST_FIRST;
            end else if (!w_in_seq) begin
                r_out_status <= swpa_pkg::ST_SEQ;
            end else begin
                r_out_status <= swpa_pkg::ST_EMIT;
                r_event      <= {w_b4, w_b3, w_b2[4:0], w_b1[4:0], r_pending};
            end
        end else if (w_load_done) begin
            if (r_dup) begin
                r_out_status <= swpa_pkg::ST_DUP;
                r_out_data   <= '0;
            end else begin
                r_out_status <= swpa_pkg::ST_EMIT;
                r_out_data   <= w_emit_data;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule

>>> tb/tb_soe_word_pair_assembler_dedup_unit.sv
module tb_soe_word_pair_assembler_dedup_unit;

    localparam int RING_DEPTH = swpa_pkg::HISTORY_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1000;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 2 * (RING_DEPTH + 2);

    // Payload bits (info bytes one to four) that the event ignores.
    localparam logic [31:0] FIRST_SPARE = 32'hC0C0_FC00;
    localparam logic [31:0] SECOND_SPARE = 32'h0000_E0E0;

    // One expected output item.
    typedef struct {
        swpa_pkg::t_status status;
        logic [11:0]       point_number;
        logic              point_state;
        logic [9:0]        milliseconds;
        logic [5:0]        seconds;
        logic [5:0]        minutes;
        logic [4:0]        hours;
        logic [4:0]        day_of_month;
    } t_soe_report;

    // Tracks the pair assembly and the duplicate ring, and checks output items.
    class t_soe_pair_board;
        logic              waiting;
        logic [21:0]       pending;
        logic [47:0]       ring [RING_DEPTH];
        int                wr_ptr;
        t_soe_report       awaited[$];
        int unsigned       faults;

        function new();
            waiting = 1'b0;
            pending = '0;
            wr_ptr = 0;
            faults = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        // Predicts the item caused by one accepted info word.
        function void take_word(logic [47:0] w);
            logic [7:0]  code;
            logic [7:0]  b1;
            logic [7:0]  b2;
            logic [7:0]  b3;
            logic [7:0]  b4;
            logic [7:0]  prev;
            logic [47:0] ev;
            logic        seen;
            t_soe_report r;
            code = w[7:0];
            b1 = w[15:8];
            b2 = w[23:16];
            b3 = w[31:24];
            b4 = w[39:32];
            prev = w[47:40];
            r.status = swpa_pkg::ST_FIRST;
            r.point_number = '0;
            r.point_state = 1'b0;
            r.milliseconds = '0;
            r.seconds = '0;
            r.minutes = '0;
            r.hours = '0;
            r.day_of_month = '0;
            if (!code[0]) begin
                // First half: latch ms, second and minute.
                pending = {b4[5:0], b3[5:0], b2[1:0], b1};
                waiting = 1'b1;
            end else if (int'(code) != int'(prev) + 1 || !waiting) begin
                r.status = swpa_pkg::ST_SEQ;
            end else begin
                waiting = 1'b0;
                ev = {b4, b3, b2[4:0], b1[4:0], pending};
                seen = 1'b0;
                foreach (ring[i]) if (ring[i] == ev) seen = 1'b1;
                if (seen) begin
                    r.status = swpa_pkg::ST_DUP;
                end else begin
                    r.status = swpa_pkg::ST_EMIT;
                    r.point_number = {b4[3:0], b3};
                    r.point_state = b4[7];
                    r.milliseconds = pending[9:0];
                    r.seconds = pending[15:10];
                    r.minutes = pending[21:16];
                    r.hours = b1[4:0];
                    r.day_of_month = b2[4:0];
                    ring[wr_ptr] = ev;
                    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                end
            end
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                faults++;
            end
        endfunction

        // Checks one accepted output item against the oldest prediction.
        function void check_item(logic [47:0] d, logic [1:0] u);
            t_soe_report e;
            if (awaited.size() == 0) begin
                $error("output item with status %0d arrived with none expected", u);
                faults++;
                return;
            end
            e = awaited.pop_front();
            compare_field("status", e.status, u);
            compare_field("point_number", e.point_number, d[11:0]);
            compare_field("point_state", e.point_state, d[12]);
            compare_field("milliseconds", e.milliseconds, d[22:13]);
            compare_field("seconds", e.seconds, d[28:23]);
            compare_field("minutes", e.minutes, d[34:29]);
            compare_field("hours", e.hours, d[39:35]);
            compare_field("day_of_month", e.day_of_month, d[44:40]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    t_soe_pair_board board = new();

    int          words_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          cycle_count = 0;
    int          ready_mode = 0;
    int          stall_left = 0;
    logic        ready_next;

    soe_word_pair_assembler_dedup_unit #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // Packs one info word as the block expects it on the input bus.
    function automatic logic [47:0] word_of(logic [7:0] code, logic [7:0] b1, logic [7:0] b2,
                                            logic [7:0] b3, logic [7:0] b4, logic [7:0] prev);
        return {prev, b4, b3, b2, b1, code};
    endfunction

    // Sends one item, opening a new burst after a random gap when the last one ran out.
    task automatic send_word(input logic [47:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.take_word(w);
        words_sent++;
    endtask

    // Receiver stall pattern, with a mode that is drawn anew at random.
    always @(negedge clk) begin
        cycle_count++;
        if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 3);
        ready_next = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else begin
            case (ready_mode)
                1: ready_next = $urandom_range(0, 1);
                2: ready_next = (cycle_count % 5) < 3;
                3: begin
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(4, 16);
                        ready_next = 1'b0;
                    end
                end
                default: ready_next = 1'b1;
            endcase
        end
        m_tready <= ready_next;
    end

    // Output monitor.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) board.check_item(m_tdata, m_tuser);
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [31:0] past_first[$];
        logic [31:0] past_second[$];
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  code;
        logic [7:0]  prev;
        int          pick;
        int          k;
        int          target;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // All-zero event hits the cleared ring and is dropped.
        send_word(word_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(word_of(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // Odd word with no first half waiting.
        send_word(word_of(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // All ones in every byte.
        send_word(word_of(8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(word_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
        // Two even words in a row; the second one wins.
        send_word(word_of(8'h10, 8'h11, 8'h02, 8'h05, 8'h07, 8'h0F));
        send_word(word_of(8'h12, 8'h34, 8'h01, 8'h3B, 8'h3B, 8'h10));
        send_word(word_of(8'h13, 8'h17, 8'h1F, 8'hAB, 8'h8C, 8'h12));
        // Previous code 255 never matches, and a wrong previous code is rejected.
        send_word(word_of(8'h20, 8'hAA, 8'h55, 8'h2A, 8'h15, 8'h00));
        send_word(word_of(8'hFF, 8'h01, 8'h01, 8'h01, 8'h01, 8'hFF));
        send_word(word_of(8'h21, 8'h01, 8'h01, 8'h01, 8'h01, 8'h21));
        send_word(word_of(8'h21, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h20));
        // Repeat of the all-ones event is a duplicate.
        send_word(word_of(8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_word(word_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
        // Same event with the ignored bits changed is still a duplicate.
        send_word(word_of(8'h40, 8'hFF, 8'h03, 8'h3F, 8'h3F, 8'h00));
        send_word(word_of(8'h41, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h40));
        // Point state low with a large point number.
        send_word(word_of(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01));
        send_word(word_of(8'h03, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'h02));

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            code = 8'($urandom) & 8'hFE;
            lo = $urandom;
            hi = $urandom;
            if (pick < 70) begin
                // Well-formed pair, often replaying an earlier event.
                if (pick < 25 && past_first.size() > 0) begin
                    k = $urandom_range(0, past_first.size() - 1);
                    lo = past_first[k] ^ (32'($urandom) & FIRST_SPARE);
                    hi = past_second[k] ^ (32'($urandom) & SECOND_SPARE);
                end
                if (pick >= 60) send_word({8'($urandom), 32'($urandom), code});
                send_word({8'($urandom), lo, code});
                send_word({code, hi, code | 8'h01});
                past_first.push_back(lo);
                past_second.push_back(hi);
                if (past_first.size() > 24) begin
                    void'(past_first.pop_front());
                    void'(past_second.pop_front());
                end
            end else if (pick < 80) begin
                // Broken pair: wrong previous code, then maybe the right one.
                prev = 8'($urandom);
                if (int'(prev) + 1 == int'(code | 8'h01)) prev = prev ^ 8'h10;
                send_word({8'($urandom), lo, code});
                send_word({prev, hi, code | 8'h01});
                if ($urandom_range(0, 1) == 1) send_word({code, hi, code | 8'h01});
            end else if (pick < 85) begin
                // Odd word that looks right but may have no first half waiting.
                send_word({code, hi, code | 8'h01});
            end else if (pick < 90) begin
                send_word({8'hFF, hi, 8'($urandom) | 8'h01});
            end else begin
                send_word({16'($urandom), lo});
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
